// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for the concurrent checks of the taskfile setup block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ATF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("taskfile setup check failed");

// expression must never be seen at a rising edge outside reset
`define ATF_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    `ATF_ASSERT(lbl, clk, rst_n, (!(expr)))

`endif

// File: rtl/ata_tf_pkg.sv
// ----------------------------------------------------------------------------
// ata_tf_pkg
// types and constants shared by the taskfile command setup modules
// ----------------------------------------------------------------------------
`default_nettype none

package ata_tf_pkg;

    // addressing modes
    localparam logic [1:0] MODE_CHS   = 2'd0;
    localparam logic [1:0] MODE_LBA28 = 2'd1;
    localparam logic [1:0] MODE_LBA48 = 2'd2;
    localparam logic [1:0] MODE_RSVD  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_ADDRESS_MODE      = 3'd0;
    localparam logic [2:0] CFG_DRIVE_SELECT      = 3'd1;
    localparam logic [2:0] CFG_HEAD_COUNT        = 3'd2;
    localparam logic [2:0] CFG_SECTORS_PER_TRACK = 3'd3;
    localparam logic [2:0] CFG_MULTI_BLOCK_SIZE  = 3'd4;

    // taskfile register indexes
    localparam logic [2:0] REG_COUNT    = 3'd0;
    localparam logic [2:0] REG_LBA_LOW  = 3'd1;
    localparam logic [2:0] REG_LBA_MID  = 3'd2;
    localparam logic [2:0] REG_LBA_HIGH = 3'd3;
    localparam logic [2:0] REG_DEVICE   = 3'd4;
    localparam logic [2:0] REG_COMMAND  = 3'd5;

    // command opcodes
    localparam logic [7:0] OP_READ     = 8'h20;
    localparam logic [7:0] OP_WRITE    = 8'h30;
    localparam logic [7:0] OP_READ_M   = 8'hC4;
    localparam logic [7:0] OP_WRITE_M  = 8'hC5;
    localparam logic [7:0] OP_READ_X   = 8'h24;
    localparam logic [7:0] OP_WRITE_X  = 8'h34;
    localparam logic [7:0] OP_READ_MX  = 8'h29;
    localparam logic [7:0] OP_WRITE_MX = 8'h39;

    // device register patterns
    localparam logic [7:0] DEV_MASTER = 8'hA0;
    localparam logic [7:0] DEV_SLAVE  = 8'hB0;
    localparam logic [7:0] DEV_LBA    = 8'h40;

    // sector count limits
    localparam logic [16:0] STD_MAX_COUNT = 17'd256;
    localparam logic [16:0] EXT_MAX_COUNT = 17'd65536;

    // chs arithmetic widths
    localparam int SPC_W      = 13;  // heads times sectors, up to 31 * 255
    localparam int CYL_STEPS  = 16;  // quotient bits of the cylinder
    localparam int HEAD_STEPS = 5;   // quotient bits of the head

    typedef struct packed {
        logic [1:0] address_mode;
        logic       drive_select;
        logic [4:0] head_count;
        logic [7:0] sectors_per_track;
        logic [7:0] multi_block_size;
    } cfg_t;

    // one classified request, ready to be played out as register writes
    typedef struct packed {
        logic        bad;
        logic        ext;
        logic [15:0] count;
        logic [7:0]  lba_b3;
        logic [7:0]  lba_b4;
        logic [7:0]  lba_b5;
        logic [7:0]  lo;
        logic [7:0]  mid;
        logic [7:0]  hi;
        logic [7:0]  dev;
        logic [7:0]  cmd;
    } desc_t;

endpackage

`default_nettype wire

// File: rtl/ata_tf_queue.sv
// ----------------------------------------------------------------------------
// ata_tf_queue
// two-entry descriptor queue between the front and the back part
// ----------------------------------------------------------------------------
`default_nettype none

module ata_tf_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  ata_tf_pkg::desc_t  push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output ata_tf_pkg::desc_t  pop_data
);

    localparam int DEPTH = 2;

    ata_tf_pkg::desc_t slot_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (fill_reg != 2'(DEPTH));
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ata_tf_front.sv
// ----------------------------------------------------------------------------
// ata_tf_front
// accepts requests, checks them and builds the taskfile descriptor
// ----------------------------------------------------------------------------
`default_nettype none

module ata_tf_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  ata_tf_pkg::cfg_t   cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_is_write,
    input  logic [47:0]        in_start_block,
    input  logic [16:0]        in_block_count,
    output logic               push_valid,
    input  logic               push_ready,
    output ata_tf_pkg::desc_t  push_desc
);

    localparam int SW = ata_tf_pkg::SPC_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SPC   = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_CYL   = 3'd3;
    localparam logic [2:0] ST_HEAD  = 3'd4;
    localparam logic [2:0] ST_PUSH  = 3'd5;

    logic [2:0]        st_reg, st_next;
    logic [3:0]        step_reg, step_next;
    logic [31:0]       lba_hi_reg, lba_hi_next;
    logic [15:0]       q_reg, q_next;
    logic [SW-1:0]     r_reg, r_next;
    logic [7:0]        p_reg, p_next;
    logic [4:0]        h_reg, h_next;
    logic [SW-1:0]     spc_reg, spc_next;
    ata_tf_pkg::desc_t hold_reg, hold_next;

    logic              ext;
    logic [16:0]       max_count;
    logic              req_bad;
    logic              go_chs;
    logic [7:0]        drv;
    logic              multi;
    logic [7:0]        cmd;
    ata_tf_pkg::desc_t direct_desc;
    logic              accept;

    logic [SW:0]       t1;
    logic [SW:0]       diff1;
    logic              ge1;
    logic [SW-1:0]     r_new;
    logic [8:0]        t2;
    logic [8:0]        diff2;
    logic              ge2;
    logic [7:0]        p_new;
    logic [4:0]        h_new;

    // request classification
    always_comb
    begin
        ext       = (cfg.address_mode == ata_tf_pkg::MODE_LBA48);
        max_count = ext ? ata_tf_pkg::EXT_MAX_COUNT : ata_tf_pkg::STD_MAX_COUNT;
        req_bad   = (cfg.address_mode == ata_tf_pkg::MODE_RSVD) ||
                    (in_block_count == 17'd0) || (in_block_count > max_count);
        go_chs    = !req_bad && (cfg.address_mode == ata_tf_pkg::MODE_CHS);
        drv       = cfg.drive_select ? ata_tf_pkg::DEV_SLAVE : ata_tf_pkg::DEV_MASTER;
        multi     = (cfg.multi_block_size > 8'd1);

        unique case ({ext, in_is_write, multi})
            3'b000:  cmd = ata_tf_pkg::OP_READ;
            3'b001:  cmd = ata_tf_pkg::OP_READ_M;
            3'b010:  cmd = ata_tf_pkg::OP_WRITE;
            3'b011:  cmd = ata_tf_pkg::OP_WRITE_M;
            3'b100:  cmd = ata_tf_pkg::OP_READ_X;
            3'b101:  cmd = ata_tf_pkg::OP_READ_MX;
            3'b110:  cmd = ata_tf_pkg::OP_WRITE_X;
            default: cmd = ata_tf_pkg::OP_WRITE_MX;
        endcase

        direct_desc        = '0;
        direct_desc.bad    = req_bad;
        direct_desc.ext    = ext;
        direct_desc.count  = (in_block_count == max_count) ? 16'd0 : in_block_count[15:0];
        direct_desc.lba_b3 = in_start_block[31:24];
        direct_desc.lba_b4 = in_start_block[39:32];
        direct_desc.lba_b5 = in_start_block[47:40];
        direct_desc.lo     = in_start_block[7:0];
        direct_desc.mid    = in_start_block[15:8];
        direct_desc.hi     = in_start_block[23:16];
        direct_desc.dev    = ext ? (ata_tf_pkg::DEV_LBA | drv)
                                 : (ata_tf_pkg::DEV_LBA | drv | {4'b0, in_start_block[27:24]});
        direct_desc.cmd    = cmd;
    end

    // one quotient bit a step: cylinder, then head
    always_comb
    begin
        t1    = {r_reg, q_reg[15]};
        diff1 = t1 - {1'b0, spc_reg};
        ge1   = (t1 >= {1'b0, spc_reg});
        r_new = ge1 ? diff1[SW-1:0] : t1[SW-1:0];

        t2    = {p_reg, h_reg[4]};
        diff2 = t2 - {1'b0, cfg.sectors_per_track};
        ge2   = (t2 >= {1'b0, cfg.sectors_per_track});
        p_new = ge2 ? diff2[7:0] : t2[7:0];
        h_new = {h_reg[3:0], ge2};
    end

    assign in_ready   = (st_reg == ST_IDLE) && push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = (st_reg == ST_IDLE) ? (in_valid && !go_chs) : (st_reg == ST_PUSH);
    assign push_desc  = (st_reg == ST_IDLE) ? direct_desc : hold_reg;

    always_comb
    begin
        st_next     = st_reg;
        step_next   = step_reg;
        lba_hi_next = lba_hi_reg;
        q_next      = q_reg;
        r_next      = r_reg;
        p_next      = p_reg;
        h_next      = h_reg;
        spc_next    = spc_reg;
        hold_next   = hold_reg;

        unique case (st_reg)
            ST_IDLE:
            begin
                if (accept && go_chs)
                begin
                    lba_hi_next = in_start_block[47:16];
                    q_next      = in_start_block[15:0];
                    hold_next   = direct_desc;
                    st_next     = ST_SPC;
                end
            end
            ST_SPC:
            begin
                spc_next = {{(SW-5){1'b0}}, cfg.head_count} *
                           {{(SW-8){1'b0}}, cfg.sectors_per_track};
                st_next  = ST_CHECK;
            end
            ST_CHECK:
            begin
                // cylinder above 16 bits exactly when the upper address reaches spc
                if ((spc_reg == '0) || (lba_hi_reg >= {{(32-SW){1'b0}}, spc_reg}))
                begin
                    hold_next.bad = 1'b1;
                    st_next       = ST_PUSH;
                end
                else
                begin
                    r_next    = lba_hi_reg[SW-1:0];
                    step_next = 4'd0;
                    st_next   = ST_CYL;
                end
            end
            ST_CYL:
            begin
                r_next    = r_new;
                q_next    = {q_reg[14:0], ge1};
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(ata_tf_pkg::CYL_STEPS - 1))
                begin
                    p_next    = r_new[SW-1:5];
                    h_next    = r_new[4:0];
                    step_next = 4'd0;
                    st_next   = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                p_next    = p_new;
                h_next    = h_new;
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(ata_tf_pkg::HEAD_STEPS - 1))
                begin
                    hold_next.lo  = p_new + 8'd1;
                    hold_next.mid = q_reg[7:0];
                    hold_next.hi  = q_reg[15:8];
                    hold_next.dev = drv | {4'b0, h_new[3:0]};
                    st_next       = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (push_ready)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            step_reg <= 4'd0;
        end
        else
        begin
            st_reg   <= st_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lba_hi_reg <= lba_hi_next;
        q_reg      <= q_next;
        r_reg      <= r_next;
        p_reg      <= p_next;
        h_reg      <= h_next;
        spc_reg    <= spc_next;
        hold_reg   <= hold_next;
    end

endmodule

`default_nettype wire

// File: rtl/ata_tf_back.sv
// ----------------------------------------------------------------------------
// ata_tf_back
// plays a descriptor out as ordered taskfile register writes
// ----------------------------------------------------------------------------
`default_nettype none

module ata_tf_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  ata_tf_pkg::desc_t  q_desc,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         out_index,
    output logic [7:0]         out_value,
    output logic               out_last,
    output logic               out_bad
);

    // non-ext commands start at the common part of the sequence
    localparam logic [3:0] COMMON_SLOT = 4'd5;

    logic              active_reg, active_next;
    logic [3:0]        step_reg, step_next;
    ata_tf_pkg::desc_t desc_reg, desc_next;
    logic              valid_reg, valid_next;
    logic [2:0]        index_reg, index_next;
    logic [7:0]        value_reg, value_next;
    logic              last_reg, last_next;
    logic              bad_reg, bad_next;

    ata_tf_pkg::desc_t src;
    logic [3:0]        cur_step;
    logic [3:0]        slot;
    logic              out_free;
    logic              fire;
    logic [2:0]        w_index;
    logic [7:0]        w_value;
    logic              w_last;

    always_comb
    begin
        src      = active_reg ? desc_reg : q_desc;
        cur_step = active_reg ? step_reg : 4'd0;
        slot     = src.ext ? cur_step : (cur_step + COMMON_SLOT);
        out_free = !valid_reg || out_ready;
        fire     = out_free && (active_reg || q_valid);

        w_last = 1'b0;
        unique case (slot)
            4'd0:
            begin
                w_index = ata_tf_pkg::REG_COUNT;
                w_value = src.count[15:8];
            end
            4'd1:
            begin
                w_index = ata_tf_pkg::REG_LBA_LOW;
                w_value = src.lba_b3;
            end
            4'd2:
            begin
                w_index = ata_tf_pkg::REG_LBA_MID;
                w_value = src.lba_b4;
            end
            4'd3:
            begin
                w_index = ata_tf_pkg::REG_LBA_HIGH;
                w_value = src.lba_b5;
            end
            4'd4:
            begin
                w_index = ata_tf_pkg::REG_DEVICE;
                w_value = 8'd0;
            end
            4'd5:
            begin
                w_index = ata_tf_pkg::REG_COUNT;
                w_value = src.count[7:0];
            end
            4'd6:
            begin
                w_index = ata_tf_pkg::REG_LBA_LOW;
                w_value = src.lo;
            end
            4'd7:
            begin
                w_index = ata_tf_pkg::REG_LBA_MID;
                w_value = src.mid;
            end
            4'd8:
            begin
                w_index = ata_tf_pkg::REG_LBA_HIGH;
                w_value = src.hi;
            end
            4'd9:
            begin
                w_index = ata_tf_pkg::REG_DEVICE;
                w_value = src.dev;
            end
            default:
            begin
                w_index = ata_tf_pkg::REG_COMMAND;
                w_value = src.cmd;
                w_last  = 1'b1;
            end
        endcase

        // rejected request: one error item and nothing else
        if (src.bad)
        begin
            w_index = ata_tf_pkg::REG_COUNT;
            w_value = 8'd0;
            w_last  = 1'b1;
        end
    end

    assign q_ready = fire && !active_reg;

    always_comb
    begin
        active_next = active_reg;
        step_next   = step_reg;
        desc_next   = desc_reg;
        index_next  = index_reg;
        value_next  = value_reg;
        last_next   = last_reg;
        bad_next    = bad_reg;
        valid_next  = out_ready ? 1'b0 : valid_reg;
        if (fire)
        begin
            valid_next  = 1'b1;
            index_next  = w_index;
            value_next  = w_value;
            last_next   = w_last;
            bad_next    = src.bad;
            active_next = !w_last;
            step_next   = cur_step + 4'd1;
            desc_next   = src;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg   <= 4'd0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            step_reg   <= step_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg  <= desc_next;
        index_reg <= index_next;
        value_reg <= value_next;
        last_reg  <= last_next;
        bad_reg   <= bad_next;
    end

    assign out_valid = valid_reg;
    assign out_index = index_reg;
    assign out_value = value_reg;
    assign out_last  = last_reg;
    assign out_bad   = bad_reg;

endmodule

`default_nettype wire

// File: rtl/ata_taskfile_command_setup_top.sv
// ----------------------------------------------------------------------------
// ata_taskfile_command_setup_top
// turns a sector transfer request into the taskfile writes of an ata pio command
// ----------------------------------------------------------------------------
// Each item on the slave stream is one transfer request (direction in tuser,
// start block and sector count in tdata). The master stream answers with the
// taskfile register writes in order, one item per write, the command byte last
// and marked by tlast: six writes in chs and lba28 mode, eleven in lba48 mode
// (count high and address bytes 3 to 5 plus a zero device write come first).
// A request with a bad count, a reserved mode, an empty chs geometry or a
// cylinder above 16 bits gives a single item with tuser set, tlast set and
// zero data. The master side carries one write per cycle while m_tready is
// high. Requests are taken while earlier ones are still being played out,
// through a two-entry queue. In chs mode the front works the address out with
// a bit-serial divider in steps (product, range check, 16 cylinder steps,
// 5 head steps, hand-over) and takes no new request until it has handed the
// result over. Configuration is to be written through the cfg channel only
// while the block is idle; the block itself does not enforce this. A write takes effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module ata_taskfile_command_setup_top
(
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // start_block [47:0], block_count [64:48], zero pad
    input  logic        s_tuser,   // is_write
    // register write stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // reg_index [2:0], reg_value [10:3], zero pad
    output logic        m_tlast,   // is_last
    output logic        m_tuser,   // bad_request
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    ata_tf_pkg::cfg_t  cfg_reg, cfg_next;

    logic              push_valid;
    logic              push_ready;
    ata_tf_pkg::desc_t push_desc;
    logic              q_valid;
    logic              q_ready;
    ata_tf_pkg::desc_t q_desc;
    logic [2:0]        out_index;
    logic [7:0]        out_value;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ata_tf_pkg::CFG_ADDRESS_MODE:      cfg_next.address_mode      = cfg_data[1:0];
                ata_tf_pkg::CFG_DRIVE_SELECT:      cfg_next.drive_select      = cfg_data[0];
                ata_tf_pkg::CFG_HEAD_COUNT:        cfg_next.head_count        = cfg_data[4:0];
                ata_tf_pkg::CFG_SECTORS_PER_TRACK: cfg_next.sectors_per_track = cfg_data;
                ata_tf_pkg::CFG_MULTI_BLOCK_SIZE:  cfg_next.multi_block_size  = cfg_data;
                default:                           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.address_mode      <= ata_tf_pkg::MODE_LBA28;
            cfg_reg.drive_select      <= 1'b0;
            cfg_reg.head_count        <= 5'd16;
            cfg_reg.sectors_per_track <= 8'd63;
            cfg_reg.multi_block_size  <= 8'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accept, check, chs conversion
    ata_tf_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_is_write    (s_tuser),
        .in_start_block (s_tdata[47:0]),
        .in_block_count (s_tdata[64:48]),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_desc      (push_desc)
    );

    // decouples the divider from the write sequencer
    ata_tf_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_desc),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_desc)
    );

    // back: one register write per cycle into the output register while m_tready does not stall it
    ata_tf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_desc    (q_desc),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (out_index),
        .out_value (out_value),
        .out_last  (m_tlast),
        .out_bad   (m_tuser)
    );

    assign m_tdata = {5'b0, out_value, out_index};

endmodule

`default_nettype wire

// File: rtl/ata_tf_checker.sv
// ----------------------------------------------------------------------------
// ata_tf_checker
// port-level checks on the register write stream of the taskfile setup block
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ata_tf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // a stalled item holds
    `ATF_ASSERT(a_out_hold, clk, rst_n, (m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))

    // an error item is marked last and carries zero data
    `ATF_ASSERT(a_bad_alone, clk, rst_n, (m_tvalid && m_tuser |-> m_tlast && (m_tdata == 16'd0)))

    // a normal run ends on the command register
    `ATF_ASSERT(a_last_cmd, clk, rst_n, (m_tvalid && m_tlast && !m_tuser |-> m_tdata[2:0] == ata_tf_pkg::REG_COMMAND))

    // no register beyond the command register, pad bits clear
    `ATF_ASSERT_NEVER(a_index_range, clk, rst_n, m_tvalid && ((m_tdata[2:0] > ata_tf_pkg::REG_COMMAND) || (m_tdata[15:11] != 5'd0)))

endmodule

bind ata_taskfile_command_setup_top ata_tf_checker u_ata_tf_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
